@@ rtl/core/bitmap_free_slot_finder_unit_defines.svh @@
// assertion macros for the bitmap free slot finder
`ifndef BITMAP_FREE_SLOT_FINDER_UNIT_DEFINES_SVH
`define BITMAP_FREE_SLOT_FINDER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BFSF_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bfsf_pkg.sv @@
// shared types, constants and helpers of the bitmap free slot finder
`default_nettype none

package bfsf_pkg;

    localparam int INDEX_W  = 10;
    localparam int SLOT_W   = 11;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int OFF_W    = 5;
    localparam int WADDR_W  = SLOT_W - OFF_W;
    localparam int NWORDS_W = WADDR_W + 1;

    localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_FIND,
        S_FINISH
    } state_t;

    // index of the lowest set bit of a bitmap word
    function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = OFF_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bfsf_if.sv @@
// request, response and configuration channels of the bitmap free slot finder
`default_nettype none

interface bfsf_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [bfsf_pkg::INDEX_W-1:0] slot_index;

    modport source (output valid, action, slot_index, input ready);
    modport sink (input valid, action, slot_index, output ready);
endinterface

interface bfsf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfsf_pkg::STATUS_W-1:0] status;
    logic [bfsf_pkg::INDEX_W-1:0]  position;

    modport source (output valid, status, position, input ready);
    modport sink (input valid, status, position, output ready);
endinterface

interface bfsf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfsf_pkg::SLOT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bfsf_word_ram.sv @@
// bitmap word memory, one write port and one registered read port
`default_nettype none

module bfsf_word_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [bfsf_pkg::WORD_W-1:0]   wr_data,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [bfsf_pkg::WORD_W-1:0]   rd_data
);
    import bfsf_pkg::*;

    logic [WORD_W-1:0] mem_array [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // read port, registered: the word read appears in the cycle after its address
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/bitmap_free_slot_finder_unit.sv @@
// top level of the bitmap free slot finder
//
// Keeps one used mark per slot in a word-wide memory (32 slots a word).
// req channel: action 0 finds the first clear slot scanning circularly from
// slot_index over the slots in use, action 1 sets the mark of slot_index.
// rsp channel: one response per request with status and position.
// cfg channel: writes slot_count, always ready; write it only while idle.
// After reset a clearing pass zeroes the memory, one word a cycle, over
// ceil(min(MAX_PIECES,1024)/32) words (32 at the default); req.ready stays
// low during it. slot_count resets to 1024.
// Out of range requests go straight to the finish state; a mark passes the
// mark state, which writes the word back; a find stays in the find state
// till a clear slot turns up or the lap ends at its start word. The scan
// reads one memory word a cycle; its single read port sets the find time.
// One request is worked on at a time; the next is taken once the response
// sits in the output register. When rsp stalls, a finished response waits
// in the output register and the following one holds until it drains.
`default_nettype none
`include "bitmap_free_slot_finder_unit_defines.svh"

module bitmap_free_slot_finder_unit #(
    parameter int MAX_PIECES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    bfsf_req_if.sink     req,
    bfsf_rsp_if.source   rsp,
    bfsf_cfg_if.sink     cfg
);
    import bfsf_pkg::*;

    localparam int STORE_SLOTS = (MAX_PIECES < (1 << INDEX_W)) ? MAX_PIECES : (1 << INDEX_W);
    localparam int STORE_WORDS = (STORE_SLOTS + WORD_W - 1) / WORD_W;
    localparam int MEM_AW      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CAP         = (MAX_PIECES < (1 << SLOT_W)) ? MAX_PIECES
                                                              : (1 << SLOT_W) - 1;

    localparam logic [SLOT_W-1:0]  COUNT_CAP     = SLOT_W'(CAP);
    localparam logic [WADDR_W-1:0] STORE_WORDS_W = WADDR_W'(STORE_WORDS);
    localparam logic [MEM_AW-1:0]  LAST_MEM_ADDR = MEM_AW'(STORE_WORDS - 1);

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    slot_count_reg;
    logic [SLOT_W-1:0]    eff_count;
    logic [MEM_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]    count_reg, count_next;
    logic [NWORDS_W-1:0]  nwords_reg, nwords_next;
    logic [WADDR_W-1:0]   word_reg, word_next;
    logic                 lap_reg, lap_next;
    logic                 rd_zero_reg, rd_zero_next;
    status_t              res_status_reg, res_status_next;
    logic [INDEX_W-1:0]   res_pos_reg, res_pos_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [INDEX_W-1:0]   out_pos_reg, out_pos_next;

    logic                 req_fire;
    logic                 req_in_range;
    logic                 out_free;
    logic                 out_load;
    logic [WADDR_W-1:0]   start_word;
    logic [OFF_W-1:0]     start_off;
    logic                 at_start;
    logic [WORD_W-1:0]    word_data;
    logic [WORD_W-1:0]    free_mask;
    logic                 any_free;
    logic [OFF_W-1:0]     hit_off;
    logic [SLOT_W-1:0]    hit_slot;
    logic [NWORDS_W-1:0]  word_inc;
    logic                 wrap;
    logic [WADDR_W-1:0]   scan_next_word;
    logic [WADDR_W-1:0]   rd_word;
    logic [SLOT_W-1:0]    rsp_pos_ext;

    logic                 wr_en;
    logic [MEM_AW-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [WORD_W-1:0]    rd_data;

    // bitmap store
    bfsf_word_ram #(
        .DEPTH  (STORE_WORDS),
        .ADDR_W (MEM_AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_word[MEM_AW-1:0]),
        .rd_data (rd_data)
    );

    // handshakes and effective slot count
    assign cfg.ready    = 1'b1;
    assign req_fire     = req.valid && req.ready;
    assign eff_count    = (slot_count_reg > COUNT_CAP) ? COUNT_CAP : slot_count_reg;
    assign req_in_range = SLOT_W'(req.slot_index) < eff_count;
    assign out_free     = !out_valid_reg || rsp.ready;

    // scan of the current word
    assign start_word = WADDR_W'(idx_reg[INDEX_W-1:OFF_W]);
    assign start_off  = idx_reg[OFF_W-1:0];
    assign at_start   = word_reg == start_word;
    assign word_data  = rd_zero_reg ? '0 : rd_data;

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            free_mask[j] = !word_data[j]
                && ((word_reg < count_reg[SLOT_W-1:OFF_W])
                    || ((word_reg == count_reg[SLOT_W-1:OFF_W])
                        && (OFF_W'(j) < count_reg[OFF_W-1:0])))
                && (!at_start
                    || (lap_reg ? (OFF_W'(j) < start_off) : (OFF_W'(j) >= start_off)));
        end
    end

    assign any_free       = |free_mask;
    assign hit_off        = lowest_set(free_mask);
    assign hit_slot       = {word_reg, hit_off};
    assign word_inc       = NWORDS_W'(word_reg) + NWORDS_W'(1);
    assign wrap           = word_inc == nwords_reg;
    assign scan_next_word = wrap ? '0 : word_inc[WADDR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_MEM_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (!req_in_range)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (req.action)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end
            S_MARK:
            begin
                state_next = S_FINISH;
            end
            S_FIND:
            begin
                if (any_free || (at_start && lap_reg))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs: request ready, memory port control, output load
    always_comb
    begin
        req.ready = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = clr_addr_reg;
        wr_data   = '0;
        rd_word   = word_reg;
        out_load  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                rd_word   = WADDR_W'(req.slot_index[INDEX_W-1:OFF_W]);
            end
            S_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = start_word[MEM_AW-1:0];
                wr_data = rd_data | (WORD_W'(1) << start_off);
            end
            S_FIND:
            begin
                rd_word = scan_next_word;
            end
            S_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign rd_zero_next = rd_word >= STORE_WORDS_W;

    // request datapath
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        nwords_next     = nwords_reg;
        word_next       = word_reg;
        lap_next        = lap_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + MEM_AW'(1);
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    idx_next        = req.slot_index;
                    count_next      = eff_count;
                    nwords_next     = NWORDS_W'(eff_count[SLOT_W-1:OFF_W])
                                      + NWORDS_W'(|eff_count[OFF_W-1:0]);
                    word_next       = WADDR_W'(req.slot_index[INDEX_W-1:OFF_W]);
                    lap_next        = 1'b0;
                    res_status_next = ST_RANGE;
                    res_pos_next    = '0;
                end
            end
            S_MARK:
            begin
                res_status_next = ST_OK;
                res_pos_next    = idx_reg;
            end
            S_FIND:
            begin
                if (any_free)
                begin
                    res_status_next = ST_OK;
                    res_pos_next    = hit_slot[INDEX_W-1:0];
                end
                else if (at_start && lap_reg)
                begin
                    res_status_next = ST_FULL;
                    res_pos_next    = '0;
                end
                else
                begin
                    word_next = scan_next_word;
                    lap_next  = lap_reg || wrap;
                end
            end
            default:
            begin
                res_pos_next = res_pos_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_pos_next    = res_pos_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            slot_count_reg <= SLOT_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                slot_count_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        nwords_reg     <= nwords_next;
        word_reg       <= word_next;
        lap_reg        <= lap_next;
        rd_zero_reg    <= rd_zero_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

    // checks
    assign rsp_pos_ext = SLOT_W'(rsp.position);

    `BFSF_ASSERT_HOLDS(a_fail_pos_zero, rsp.valid && (rsp.status != ST_OK), rsp.position == '0, "failed response carries a nonzero position")
    `BFSF_ASSERT_HOLDS(a_ok_pos_in_count, rsp.valid && (rsp.status == ST_OK), rsp_pos_ext < eff_count, "response position beyond the slot count")
    `BFSF_ASSERT_NEXT(a_range_status, req_fire && !req_in_range, res_status_reg == ST_RANGE, "out of range request not flagged")
    `BFSF_ASSERT_HOLDS(a_scan_stops_at_start, (state_reg == S_FIND) && lap_reg, word_reg <= start_word, "wrapped scan ran past its start word")

endmodule

`default_nettype wire
